[rtl/ntp_pkg.sv]
// Shared types, character constants and code functions for the triplet packer.
`timescale 1ns / 1ps
`default_nettype none

package ntp_pkg;

    // Character bytes recognized by the parser.
    localparam logic [7:0] NEWLINE_BYTE = 8'h0A;
    localparam logic [7:0] HEADER_MARK  = 8'h3E;
    localparam logic [7:0] CASE_GAP     = 8'd32;
    localparam logic [7:0] CHAR_A       = 8'h41;
    localparam logic [7:0] CHAR_C       = 8'h43;
    localparam logic [7:0] CHAR_G       = 8'h47;
    localparam logic [7:0] CHAR_N       = 8'h4E;
    localparam logic [7:0] CHAR_T       = 8'h54;
    localparam logic [7:0] LOWER_A      = 8'h61;
    localparam logic [7:0] LOWER_C      = 8'h63;
    localparam logic [7:0] LOWER_G      = 8'h67;
    localparam logic [7:0] LOWER_N      = 8'h6E;
    localparam logic [7:0] LOWER_T      = 8'h74;

    // Base indices in the order A, C, G, N, T; anything else is unknown.
    localparam logic [2:0] IDX_A       = 3'd0;
    localparam logic [2:0] IDX_C       = 3'd1;
    localparam logic [2:0] IDX_G       = 3'd2;
    localparam logic [2:0] IDX_N       = 3'd3;
    localparam logic [2:0] IDX_T       = 3'd4;
    localparam logic [2:0] UNKNOWN_IDX = 3'd7;

    // Code arithmetic constants.
    localparam logic [7:0] BASE_COUNT  = 8'd5;
    localparam logic [7:0] BASE_SQUARE = 8'd25;
    localparam logic [7:0] PAIR_BASE   = 8'd125;
    localparam logic [7:0] SINGLE_BASE = 8'd150;
    localparam logic [7:0] CODE_MAX    = 8'd154;

    // Action codes carried in tuser.
    localparam logic ACT_TEXT  = 1'b0;
    localparam logic ACT_FLUSH = 1'b1;

    typedef logic [2:0] t_idx;

    // One registered input beat.
    typedef struct packed {
        logic       action;
        logic [7:0] symbol;
    } t_beat;

    // Result of one beat as seen by the output register.
    typedef struct packed {
        logic       valid;
        logic [7:0] code;
    } t_result;

    // Parser status exported to the top level.
    typedef struct packed {
        logic [1:0] held_count;
        logic       in_header_line;
    } t_status;

    // Maps a text byte to its base index, folding the five lowercase letters.
    function automatic t_idx base_index(input logic [7:0] b);
        logic [7:0] u;
        u = b;
        if (b == LOWER_A || b == LOWER_C || b == LOWER_G ||
            b == LOWER_N || b == LOWER_T) begin
            u = b - CASE_GAP;
        end
        unique case (u)
            CHAR_A:  base_index = IDX_A;
            CHAR_C:  base_index = IDX_C;
            CHAR_G:  base_index = IDX_G;
            CHAR_N:  base_index = IDX_N;
            CHAR_T:  base_index = IDX_T;
            default: base_index = UNKNOWN_IDX;
        endcase
    endfunction

    // Full group code 25*i1 + 5*i2 + i3, or zero if any index is unknown.
    function automatic logic [7:0] triplet_code(input t_idx f, input t_idx s, input t_idx t);
        if (f == UNKNOWN_IDX || s == UNKNOWN_IDX || t == UNKNOWN_IDX) begin
            triplet_code = 8'd0;
        end else begin
            triplet_code = {5'd0, f} * BASE_SQUARE + {5'd0, s} * BASE_COUNT + {5'd0, t};
        end
    endfunction

    // Two-symbol flush code 125 + 5*i1 + i2, or zero if unknown.
    function automatic logic [7:0] pair_code(input t_idx f, input t_idx s);
        if (f == UNKNOWN_IDX || s == UNKNOWN_IDX) begin
            pair_code = 8'd0;
        end else begin
            pair_code = PAIR_BASE + {5'd0, f} * BASE_COUNT + {5'd0, s};
        end
    endfunction

    // One-symbol flush code 150 + i1, or zero if unknown.
    function automatic logic [7:0] single_code(input t_idx f);
        if (f == UNKNOWN_IDX) begin
            single_code = 8'd0;
        end else begin
            single_code = SINGLE_BASE + {5'd0, f};
        end
    endfunction

endpackage

`default_nettype wire

[rtl/ntp_core.sv]
// Line parser and group state: turns one registered beat into an optional code.
`timescale 1ns / 1ps
`default_nettype none

module ntp_core
    import ntp_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_advance,
    input  wire t_beat   i_beat,
    output t_result      o_result,
    output t_status      o_status
);

    logic [1:0] r_held_count, n_held_count;
    t_idx       r_first_held, n_first_held;
    t_idx       r_second_held, n_second_held;
    logic       r_at_line_start, n_at_line_start;
    logic       r_in_header_line, n_in_header_line;
    t_idx       w_idx;

    assign w_idx = base_index(i_beat.symbol);

    // Next state and result for the beat held in the input register.
    always_comb begin
        n_held_count     = r_held_count;
        n_first_held     = r_first_held;
        n_second_held    = r_second_held;
        n_at_line_start  = r_at_line_start;
        n_in_header_line = r_in_header_line;
        o_result         = '0;

        if (i_beat.action == ACT_FLUSH) begin
            // End of stream: emit a partial group if one is held, then restart.
            case (r_held_count)
                2'd1: begin
                    o_result.valid = 1'b1;
                    o_result.code  = single_code(r_first_held);
                end
                2'd2: begin
                    o_result.valid = 1'b1;
                    o_result.code  = pair_code(r_first_held, r_second_held);
                end
                default: o_result = '0;
            endcase
            n_held_count     = 2'd0;
            n_first_held     = '0;
            n_second_held    = '0;
            n_at_line_start  = 1'b1;
            n_in_header_line = 1'b0;
        end else if (i_beat.symbol == NEWLINE_BYTE) begin
            n_at_line_start  = 1'b1;
            n_in_header_line = 1'b0;
        end else if (r_at_line_start && i_beat.symbol == HEADER_MARK) begin
            n_at_line_start  = 1'b0;
            n_in_header_line = 1'b1;
        end else begin
            n_at_line_start = 1'b0;
            if (!r_in_header_line) begin
                // A sequence symbol fills the next slot of the group.
                case (r_held_count)
                    2'd0: begin
                        n_first_held = w_idx;
                        n_held_count = 2'd1;
                    end
                    2'd1: begin
                        n_second_held = w_idx;
                        n_held_count  = 2'd2;
                    end
                    default: begin
                        o_result.valid = 1'b1;
                        o_result.code  = triplet_code(r_first_held, r_second_held, w_idx);
                        n_held_count   = 2'd0;
                        n_first_held   = '0;
                        n_second_held  = '0;
                    end
                endcase
            end
        end
    end

    // State moves only when the beat leaves the input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_count     <= 2'd0;
            r_first_held     <= '0;
            r_second_held    <= '0;
            r_at_line_start  <= 1'b1;
            r_in_header_line <= 1'b0;
        end else if (i_advance) begin
            r_held_count     <= n_held_count;
            r_first_held     <= n_first_held;
            r_second_held    <= n_second_held;
            r_at_line_start  <= n_at_line_start;
            r_in_header_line <= n_in_header_line;
        end
    end

    assign o_status.held_count     = r_held_count;
    assign o_status.in_header_line = r_in_header_line;

endmodule

`default_nettype wire

[rtl/nucleotide_triplet_packer_unit.sv]
// Top level: FASTA byte stream in, packed triplet codes out.
//
//  Port group   Dir  Role                     Beat content
//  s_axis_*     in   text bytes and flushes   tdata: symbol; tuser: action
//  m_axis_*     out  packed group codes       tdata: code
//
// One beat is accepted per cycle when the output side keeps up; the beat
// that completes a group is held in the input register, and its code then
// in the result register. The parser state and the result register sit
// on either side of one short combinational step.
// Reset is synchronous and active low; it empties both registers and puts
// the parser at the start of a line with no symbols held. A stalled output
// holds the input register, and s_axis_tready falls only when both are full.
`timescale 1ns / 1ps
`default_nettype none

module nucleotide_triplet_packer_unit
    import ntp_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,

    input  wire logic       s_axis_tvalid,
    output logic            s_axis_tready,
    input  wire logic [7:0] s_axis_tdata,   // [7:0] symbol
    input  wire logic       s_axis_tuser,   // [0] action

    output logic            m_axis_tvalid,
    input  wire logic       m_axis_tready,
    output logic [7:0]      m_axis_tdata    // [7:0] code
);

    logic       r_in_valid;
    t_beat      r_in;
    logic       r_out_valid;
    logic [7:0] r_out_code;
    logic       w_advance;
    t_result    w_result;
    t_status    w_status;

    // The input beat moves on whenever the result register can take a code.
    assign w_advance     = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_advance;

    ntp_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (w_advance),
        .i_beat    (r_in),
        .o_result  (w_result),
        .o_status  (w_status)
    );

    // Valid flags of the input and result registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                r_in_valid <= 1'b1;
            end else if (w_advance) begin
                r_in_valid <= 1'b0;
            end
            if (w_advance && w_result.valid) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in.action <= s_axis_tuser;
            r_in.symbol <= s_axis_tdata;
        end
        if (w_advance && w_result.valid) begin
            r_out_code <= w_result.code;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_code;

    // A group never holds three symbols between beats.
    a_held_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_status.held_count != 2'd3)
        else $error("held symbol count out of range");

    // A flush leaves the group empty and the parser outside any header.
    a_flush_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && r_in.action == ACT_FLUSH) |=>
        (w_status.held_count == 2'd0 && !w_status.in_header_line))
        else $error("flush did not clear the group state");

    // A held input beat keeps its contents while the output is stalled.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_advance) |=> (r_in_valid && $stable(r_in)))
        else $error("input register changed while stalled");

    // Every emitted code lies in the defined code range.
    a_code_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_code <= CODE_MAX))
        else $error("code out of range");

endmodule

`default_nettype wire

[test/nucleotide_triplet_packer_checker.sv]
// Checker for the triplet packer: predicts codes from input beats and compares output beats.
`timescale 1ns / 1ps

module nucleotide_triplet_packer_checker
    import ntp_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,

    input  wire logic       i_in_valid,
    input  wire logic       i_in_ready,
    input  wire logic [7:0] i_in_data,      // [7:0] symbol
    input  wire logic       i_in_user,      // [0] action

    input  wire logic       i_out_valid,
    input  wire logic       i_out_ready,
    input  wire logic [7:0] i_out_data,     // [7:0] code

    output int              o_fail_count,
    output int              o_pending,
    output int              o_codes_checked
);

    // Codes predicted but not yet seen on the output, oldest first.
    logic [7:0] predicted_codes [$];
    logic [7:0] oldest_code;

    // Private copy of the parser state.
    t_idx       grp_first;
    t_idx       grp_second;
    logic [1:0] grp_fill;
    logic       line_fresh;
    logic       skipping_header;

    int fail_total    = 0;
    int checked_total = 0;

    // Base index of a text byte; the five lowercase letters fold to uppercase.
    function automatic t_idx fold_base(input logic [7:0] b);
        case (b)
            CHAR_A, LOWER_A: fold_base = IDX_A;
            CHAR_C, LOWER_C: fold_base = IDX_C;
            CHAR_G, LOWER_G: fold_base = IDX_G;
            CHAR_N, LOWER_N: fold_base = IDX_N;
            CHAR_T, LOWER_T: fold_base = IDX_T;
            default:         fold_base = UNKNOWN_IDX;
        endcase
    endfunction

    // Advances the parser by one accepted beat and queues any code it completes.
    task automatic parse_beat(input logic act, input logic [7:0] sym);
        t_idx       idx;
        logic [7:0] value;
        if (act == ACT_FLUSH) begin
            if (grp_fill == 2'd1) begin
                value = (grp_first == UNKNOWN_IDX) ? 8'd0 : SINGLE_BASE + 8'(grp_first);
                predicted_codes.push_back(value);
            end else if (grp_fill == 2'd2) begin
                if (grp_first == UNKNOWN_IDX || grp_second == UNKNOWN_IDX) begin
                    value = 8'd0;
                end else begin
                    value = PAIR_BASE + BASE_COUNT * 8'(grp_first) + 8'(grp_second);
                end
                predicted_codes.push_back(value);
            end
            grp_fill        = 2'd0;
            grp_first       = IDX_A;
            grp_second      = IDX_A;
            line_fresh      = 1'b1;
            skipping_header = 1'b0;
        end else if (sym == NEWLINE_BYTE) begin
            line_fresh      = 1'b1;
            skipping_header = 1'b0;
        end else if (line_fresh && sym == HEADER_MARK) begin
            line_fresh      = 1'b0;
            skipping_header = 1'b1;
        end else begin
            line_fresh = 1'b0;
            if (!skipping_header) begin
                idx = fold_base(sym);
                case (grp_fill)
                    2'd0: begin
                        grp_first = idx;
                        grp_fill  = 2'd1;
                    end
                    2'd1: begin
                        grp_second = idx;
                        grp_fill   = 2'd2;
                    end
                    default: begin
                        // The third symbol closes the group.
                        if (grp_first == UNKNOWN_IDX || grp_second == UNKNOWN_IDX ||
                            idx == UNKNOWN_IDX) begin
                            value = 8'd0;
                        end else begin
                            value = BASE_SQUARE * 8'(grp_first) +
                                    BASE_COUNT * 8'(grp_second) + 8'(idx);
                        end
                        predicted_codes.push_back(value);
                        grp_fill   = 2'd0;
                        grp_first  = IDX_A;
                        grp_second = IDX_A;
                    end
                endcase
            end
        end
    endtask

    // Output beats are checked before the same edge's input beat is parsed,
    // since a code never leaves in the cycle its beat enters.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            predicted_codes.delete();
            grp_first       = IDX_A;
            grp_second      = IDX_A;
            grp_fill        = 2'd0;
            line_fresh      = 1'b1;
            skipping_header = 1'b0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (predicted_codes.size() == 0) begin
                    $error("code beat with no code predicted: actual %0d", i_out_data);
                    fail_total++;
                end else begin
                    oldest_code = predicted_codes.pop_front();
                    checked_total++;
                    if (i_out_data !== oldest_code) begin
                        $error("code mismatch: expected %0d, actual %0d",
                               oldest_code, i_out_data);
                        fail_total++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                parse_beat(i_in_user, i_in_data);
            end
        end
        o_fail_count    <= fail_total;
        o_pending       <= predicted_codes.size();
        o_codes_checked <= checked_total;
    end

endmodule

[test/nucleotide_triplet_packer_unit_tb.sv]
// Testbench top: feeds FASTA-like byte streams to the packer and gives the verdict.
`timescale 1ns / 1ps

module nucleotide_triplet_packer_unit_tb;
    import ntp_pkg::*;

    localparam int CYCLE_LIMIT  = 500000;
    localparam int RANDOM_BEATS = 1250;
    localparam int DRAIN_CYCLES = 8;

    logic       i_clk         = 1'b0;
    logic       i_rst_n       = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic [7:0] s_axis_tdata  = 8'h00;
    logic       s_axis_tuser  = ACT_TEXT;
    logic       m_axis_tready = 1'b0;
    wire        s_axis_tready;
    wire        m_axis_tvalid;
    wire  [7:0] m_axis_tdata;

    int fail_count;
    int pending_codes;
    int codes_checked;

    int cycle_count  = 0;
    int beats_sent   = 0;
    int flushes_sent = 0;
    int stall_left   = 0;
    bit feed_calm    = 1'b0;
    bit drain_calm   = 1'b0;

    nucleotide_triplet_packer_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // [7:0] symbol
        .s_axis_tuser  (s_axis_tuser),   // [0] action
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)    // [7:0] code
    );

    nucleotide_triplet_packer_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (s_axis_tvalid),
        .i_in_ready      (s_axis_tready),
        .i_in_data       (s_axis_tdata),  // [7:0] symbol
        .i_in_user       (s_axis_tuser),  // [0] action
        .i_out_valid     (m_axis_tvalid),
        .i_out_ready     (m_axis_tready),
        .i_out_data      (m_axis_tdata),  // [7:0] code
        .o_fail_count    (fail_count),
        .o_pending       (pending_codes),
        .o_codes_checked (codes_checked)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    // Length of an idle stretch: mostly none, often short, now and then long.
    function automatic int idle_len(input bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 65) begin
            idle_len = 0;
        end else if (r < 90) begin
            idle_len = $urandom_range(1, 3);
        end else if (r < 98) begin
            idle_len = $urandom_range(4, 8);
        end else begin
            idle_len = $urandom_range(20, 60);
        end
    endfunction

    // Output side: random back-pressure, with calm stretches of full speed.
    always @(posedge i_clk) begin
        if ($urandom_range(0, 299) == 0) begin
            drain_calm = !drain_calm;
        end
        if (stall_left > 0) begin
            m_axis_tready <= 1'b0;
            stall_left--;
        end else begin
            m_axis_tready <= 1'b1;
            stall_left = idle_len(drain_calm);
        end
    end

    // Presents one beat after an optional idle gap and waits for its handshake.
    task automatic send_beat(input logic act, input logic [7:0] sym);
        int gap;
        gap = idle_len(feed_calm);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= sym;
        s_axis_tuser  <= act;
        do @(posedge i_clk); while (!s_axis_tready);
        beats_sent++;
        if (act == ACT_FLUSH) begin
            flushes_sent++;
        end
    endtask

    task automatic send_text(input string s);
        for (int k = 0; k < s.len(); k++) begin
            send_beat(ACT_TEXT, s[k]);
        end
    endtask

    function automatic logic [7:0] pick_base();
        case ($urandom_range(0, 9))
            0:       pick_base = CHAR_A;
            1:       pick_base = CHAR_C;
            2:       pick_base = CHAR_G;
            3:       pick_base = CHAR_N;
            4:       pick_base = CHAR_T;
            5:       pick_base = LOWER_A;
            6:       pick_base = LOWER_C;
            7:       pick_base = LOWER_G;
            8:       pick_base = LOWER_N;
            default: pick_base = LOWER_T;
        endcase
    endfunction

    // Sequence-line byte: mostly bases, some stray bytes, carriage returns and '>'.
    function automatic logic [7:0] pick_symbol();
        int r;
        r = $urandom_range(0, 99);
        if (r < 86) begin
            pick_symbol = pick_base();
        end else if (r < 93) begin
            pick_symbol = 8'($urandom_range(0, 255));
        end else if (r < 97) begin
            pick_symbol = 8'h0D;
        end else begin
            pick_symbol = HEADER_MARK;
        end
    endfunction

    // One random record: an optional header, a few sequence lines, usually a flush.
    // A small share of records is raw noise with flushes mixed in.
    task automatic send_record();
        int lines;
        int len;
        if ($urandom_range(0, 9) == 0) begin
            feed_calm = !feed_calm;
        end
        if ($urandom_range(0, 19) == 0) begin
            repeat ($urandom_range(1, 12)) begin
                send_beat(($urandom_range(0, 3) == 0) ? ACT_FLUSH : ACT_TEXT,
                          8'($urandom_range(0, 255)));
            end
        end else begin
            if ($urandom_range(0, 9) < 3) begin
                send_beat(ACT_TEXT, HEADER_MARK);
                repeat ($urandom_range(0, 15)) begin
                    send_beat(ACT_TEXT, 8'($urandom_range(32, 126)));
                end
                send_beat(ACT_TEXT, NEWLINE_BYTE);
            end
            lines = $urandom_range(1, 4);
            repeat (lines) begin
                len = $urandom_range(0, 30);
                repeat (len) send_beat(ACT_TEXT, pick_symbol());
                if ($urandom_range(0, 9) != 0) begin
                    send_beat(ACT_TEXT, NEWLINE_BYTE);
                end
            end
            if ($urandom_range(0, 4) != 0) begin
                send_beat(ACT_FLUSH, 8'($urandom_range(0, 255)));
            end
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Full groups in upper and lower case, then a line break.
        send_text("ACG");
        send_text("tnT");
        send_beat(ACT_TEXT, NEWLINE_BYTE);
        // A header line is skipped whole, bases in it included.
        send_text(">hA");
        send_beat(ACT_TEXT, NEWLINE_BYTE);
        // A '>' inside a line is just an unknown symbol.
        send_text("A>C");
        // Carriage return and NUL poison their group.
        send_text("a");
        send_beat(ACT_TEXT, 8'h0D);
        send_beat(ACT_TEXT, 8'h00);
        // An all-ones byte alone, flushed with a junk symbol field.
        send_beat(ACT_TEXT, 8'hFF);
        send_beat(ACT_FLUSH, 8'hFF);
        // Flush with nothing held gives no code.
        send_beat(ACT_FLUSH, 8'h00);
        // Largest single and pair codes.
        send_text("T");
        send_beat(ACT_FLUSH, 8'h00);
        send_text("TT");
        send_beat(ACT_FLUSH, 8'h00);
        // Flush inside a header line puts the parser back at a line start.
        send_text(">A");
        send_beat(ACT_FLUSH, 8'h00);
        send_text("gc");
        send_beat(ACT_FLUSH, 8'h00);

        while (beats_sent < RANDOM_BEATS) begin
            send_record();
        end
        s_axis_tvalid <= 1'b0;

        // Drain: wait for every predicted code.
        @(posedge i_clk);
        while (pending_codes != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Summary: %0d input beats, %0d of them end-of-stream flushes, with headers,",
                 beats_sent, flushes_sent);
        $display("Summary: stray bytes and random gaps on both sides; %0d codes compared.",
                 codes_checked);
        if (fail_count == 0) begin
            $display("nucleotide_triplet_packer_unit_tb passed");
        end else begin
            $display("nucleotide_triplet_packer_unit_tb failed");
        end
        $finish;
    end

    // Watchdog on the cycle counter.
    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("nucleotide_triplet_packer_unit_tb failed");
        $finish;
    end

endmodule

[nucleotide_triplet_packer_unit.f]
rtl/ntp_pkg.sv
rtl/ntp_core.sv
rtl/nucleotide_triplet_packer_unit.sv
test/nucleotide_triplet_packer_checker.sv
test/nucleotide_triplet_packer_unit_tb.sv
